[rtl/ida_pkg.sv]
package ida_pkg;
	localparam int DataWidthDefault = 32;
	localparam int OpWidth = 4;
	localparam int StWidth = 2;

	localparam logic [OpWidth-1:0] OP_ADD  = 4'd0;
	localparam logic [OpWidth-1:0] OP_SUB  = 4'd1;
	localparam logic [OpWidth-1:0] OP_MUL  = 4'd2;
	localparam logic [OpWidth-1:0] OP_QUOT = 4'd3;
	localparam logic [OpWidth-1:0] OP_MOD  = 4'd4;
	localparam logic [OpWidth-1:0] OP_DIV  = 4'd5;
	localparam logic [OpWidth-1:0] OP_MIN  = 4'd6;
	localparam logic [OpWidth-1:0] OP_MAX  = 4'd7;
	localparam logic [OpWidth-1:0] OP_POW  = 4'd8;

	localparam logic [StWidth-1:0] ST_OK     = 2'd0;
	localparam logic [StWidth-1:0] ST_OVF    = 2'd1;
	localparam logic [StWidth-1:0] ST_DOMAIN = 2'd2;
	localparam logic [StWidth-1:0] ST_REAL   = 2'd3;
endpackage

[rtl/ida_divider.sv]
// Restoring divider for nonnegative operands, one quotient bit per stage.
// Every stage is a register; the whole chain advances on en.
module ida_divider import ida_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDefault
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);
	logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_s [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] den_s [DATA_WIDTH+1];

	always_comb begin
		rem_s[0] = '0;
		quo_s[0] = dividend;
		den_s[0] = divisor;
	end

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
		logic [DATA_WIDTH:0] shifted;
		logic [DATA_WIDTH:0] diff;
		assign shifted = {rem_s[i], quo_s[i][DATA_WIDTH-1]};
		assign diff = shifted - {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				if (!diff[DATA_WIDTH]) begin
					rem_s[i+1] <= diff[DATA_WIDTH-1:0];
					quo_s[i+1] <= {quo_s[i][DATA_WIDTH-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shifted[DATA_WIDTH-1:0];
					quo_s[i+1] <= {quo_s[i][DATA_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient  = quo_s[DATA_WIDTH];
	assign remainder = rem_s[DATA_WIDTH];
endmodule

[rtl/int_dyadic_alu_overflow_core.sv]
// Depth: DATA_WIDTH + 3 register stages; the result of an input transfer passes
// stage 1, stage 2, the divider stages and the final stage before it is offered.
// Throughput: one item per cycle while not stalled; a stall at the output freezes the
// whole pipe, and stalls the input, only when the final stage holds a waiting result.
// Reset: arst_n clears every stage valid bit at once; payload registers are not reset.
module int_dyadic_alu_overflow_core import ida_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [OpWidth-1:0]           operation,
	input  logic signed [DATA_WIDTH-1:0] x_operand,
	input  logic signed [DATA_WIDTH-1:0] y_operand,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] int_result,
	output logic [StWidth-1:0]           status
);
	localparam int W = DATA_WIDTH;
	localparam int H = (W + 1) / 2;
	localparam int D = W + 3;

	// The pipe moves as one unit. It advances whenever the last stage is empty
	// or its result is taken in this cycle.
	logic adv;
	logic [D-1:0] vld_q;
	assign adv = !vld_q[D-1] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[D-2:0], in_valid};
		end
	end

	// Stage 1: register operands, magnitudes and the product sign.
	logic [OpWidth-1:0] op_s1;
	logic signed [W-1:0] x_s1, y_s1;
	logic [W-1:0] ax_s1, ay_s1;
	logic neg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= operation;
			x_s1   <= x_operand;
			y_s1   <= y_operand;
			ax_s1  <= x_operand[W-1] ? W'(-x_operand) : x_operand;
			ay_s1  <= y_operand[W-1] ? W'(-y_operand) : y_operand;
			neg_s1 <= x_operand[W-1] ^ y_operand[W-1];
		end
	end

	// Stage 2: partial products of the magnitude product, plus add, sub, min, max and the status checks.
	logic [H-1:0] xl, xh, yl, yh;
	assign xl = ax_s1[H-1:0];
	assign yl = ay_s1[H-1:0];
	assign xh = H'(ax_s1 >> H);
	assign yh = H'(ay_s1 >> H);

	logic [2*H-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [OpWidth-1:0] op_s2;
	logic neg_s2;
	logic [W-1:0] dx_s2, dy_s2;
	logic [W-1:0] simple_r_s2;
	logic [StWidth-1:0] simple_st_s2;
	logic [W-1:0] sum, dif;
	logic [W-1:0] simple_r;
	logic [StWidth-1:0] simple_st;
	assign sum = x_s1 + y_s1;
	assign dif = x_s1 - y_s1;

	// Mod and div with a good operand pair leave a zero here; the divider
	// supplies their result in the final stage.
	always_comb begin
		simple_r  = '0;
		simple_st = ST_OK;
		case (op_s1)
			OP_ADD: begin
				if ((x_s1[W-1] ^ sum[W-1]) & (y_s1[W-1] ^ sum[W-1])) simple_st = ST_OVF;
				else simple_r = sum;
			end
			OP_SUB: begin
				if ((x_s1[W-1] ^ y_s1[W-1]) & (x_s1[W-1] ^ dif[W-1])) simple_st = ST_OVF;
				else simple_r = dif;
			end
			OP_MIN: simple_r = (y_s1 < x_s1) ? y_s1 : x_s1;
			OP_MAX: simple_r = (x_s1 < y_s1) ? y_s1 : x_s1;
			OP_MOD, OP_DIV: begin
				if (x_s1[W-1] || y_s1[W-1] || y_s1 == '0) simple_st = ST_DOMAIN;
			end
			OP_MUL: simple_st = ST_OK;
			default: simple_st = ST_REAL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s2 <= xl * yl;
			p01_s2 <= xl * yh;
			p10_s2 <= xh * yl;
			p11_s2 <= xh * yh;
			op_s2  <= op_s1;
			neg_s2 <= neg_s1;
			dx_s2  <= x_s1;
			dy_s2  <= y_s1;
			simple_r_s2  <= simple_r;
			simple_st_s2 <= simple_st;
		end
	end

	// Stage 3: sum the partial products and check the fit.
	logic [4*H-1:0] prod;
	assign prod = {{(2*H){1'b0}}, p00_s2} + ({{(2*H){1'b0}}, p01_s2} << H)
		+ ({{(2*H){1'b0}}, p10_s2} << H) + {p11_s2, {(2*H){1'b0}}};
	logic [W-1:0] maxpos;
	assign maxpos = {1'b0, {(W-1){1'b1}}};

	logic [W-1:0] mul_r;
	logic [StWidth-1:0] mul_st;
	always_comb begin
		if (prod[4*H-1:W] != '0 ||
		    prod[W-1:0] > (neg_s2 ? maxpos + W'(1) : maxpos)) begin
			mul_st = ST_OVF;
			mul_r  = '0;
		end else begin
			mul_st = ST_OK;
			mul_r  = neg_s2 ? W'(-prod[W-1:0]) : prod[W-1:0];
		end
	end

	logic [OpWidth-1:0] op_s3;
	logic [W-1:0] r_s3;
	logic [StWidth-1:0] st_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			r_s3  <= (op_s2 == OP_MUL) ? mul_r : simple_r_s2;
			st_s3 <= (op_s2 == OP_MUL) ? mul_st : simple_st_s2;
		end
	end

	// The divider takes its operands from stage 2 and spans stages 3 to W+2.
	logic [W-1:0] quo, rem;
	ida_divider #(.DATA_WIDTH(W)) u_div (
		.clk(clk), .en(adv),
		.dividend(dx_s2), .divisor(dy_s2),
		.quotient(quo), .remainder(rem)
	);

	// Delay line bringing the stage 3 results level with the divider output.
	logic [OpWidth-1:0] op_d [D-3];
	logic [W-1:0] r_d [D-3];
	logic [StWidth-1:0] st_d [D-3];
	always_comb begin
		op_d[0] = op_s3;
		r_d[0]  = r_s3;
		st_d[0] = st_s3;
	end
	for (genvar k = 1; k < D-3; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				op_d[k] <= op_d[k-1];
				r_d[k]  <= r_d[k-1];
				st_d[k] <= st_d[k-1];
			end
		end
	end

	logic [OpWidth-1:0] op_f;
	logic [W-1:0] r_f;
	logic [StWidth-1:0] st_f;
	assign op_f = op_d[D-4];
	assign r_f  = r_d[D-4];
	assign st_f = st_d[D-4];

	// Final stage: pick the division output for good mod and div transfers.
	logic [W-1:0] res_q;
	logic [StWidth-1:0] st_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= st_f;
			if (st_f == ST_OK && op_f == OP_MOD) res_q <= rem;
			else if (st_f == ST_OK && op_f == OP_DIV) res_q <= quo;
			else res_q <= r_f;
		end
	end

	assign out_valid  = vld_q[D-1];
	assign int_result = res_q;
	assign status     = st_q;

	// A result held under stall must keep its valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	// A nonzero status always comes with a zero result.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> int_result == '0)
		else $error("nonzero result with error status");
	// The input side stalls only when the output side holds a result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("spurious input stall");
endmodule
